@@ rtl/lmsw_pkg.sv @@
package lmsw_pkg;

    // Field widths of the request and result channels.
    localparam int OP_W        = 2;
    localparam int CMD_W       = 8;
    localparam int LEVEL_W     = 8;
    localparam int LED_INDEX_W = 9;
    localparam int NIBBLE_W    = 4;

    // Size of the LED shadow store, in nibbles.
    localparam int NIBBLE_ADDRESSES = 128;
    localparam int RAM_ADDR_W       = $clog2(NIBBLE_ADDRESSES);

    // The frame always carries a full seven-bit nibble address.
    localparam int FRAME_ADDR_W = LED_INDEX_W - 2;

    // Frame layout: the longest frame is fourteen bits.
    localparam int FRAME_W  = 14;
    localparam int COUNT_W  = 4;
    localparam int FRAME_ID_W = 3;

    localparam logic [COUNT_W-1:0] CMD_FRAME_BITS = 4'd12;
    localparam logic [COUNT_W-1:0] LED_FRAME_BITS = 4'd14;

    localparam logic [FRAME_ID_W-1:0] ID_COMMAND = 3'b100;
    localparam logic [FRAME_ID_W-1:0] ID_WRITE   = 3'b101;

    // Brightness handling.
    localparam logic [CMD_W-1:0]    BRIGHTNESS_BASE_RESET = 8'd160;
    localparam logic [NIBBLE_W-1:0] LEVEL_MAX             = 4'd15;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_RAW_CMD    = 2'd0,
        OP_BRIGHTNESS = 2'd1,
        OP_SET_LED    = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

endpackage

@@ rtl/lmsw_if.sv @@
// Request channel: one operation for the serial writer.
interface lmsw_req_if;
    import lmsw_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               op;
    logic [CMD_W-1:0]              cmd_byte;
    logic signed [LEVEL_W-1:0]     level;
    logic [LED_INDEX_W-1:0]        led_index;
    logic                          led_value;

    modport source (
        output valid, op, cmd_byte, level, led_index, led_value,
        input  ready
    );
    modport sink (
        input  valid, op, cmd_byte, level, led_index, led_value,
        output ready
    );
endinterface

// Result channel: one serial bit of a frame.
interface lmsw_res_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic frame_first;
    logic last;

    modport source (
        output valid, data_bit, frame_first, last,
        input  ready
    );
    modport sink (
        input  valid, data_bit, frame_first, last,
        output ready
    );
endinterface

@@ rtl/lmsw_ram.sv @@
module lmsw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/led_matrix_serial_writer_core.sv @@
// Channel   Direction  Payload                                        Handshake
// req       in         op, cmd_byte, level, led_index, led_value      valid/ready
// res       out        data_bit, frame_first, last                    valid/ready
// cfg       in         cfg_data (brightness command base)             cfg_we only
//
// A command or brightness request is loaded straight into a twelve-bit frame.
// A set-LED request first reads the shadow nibble, then modifies and writes it back
// while loading a fourteen-bit frame; the single bit shift register holds one frame.
// Requests with an unused op code are accepted and dropped; every LED address is in range.
// The shadow store reads as zero after reset through per-nibble valid flops.
// A stalled result holds the shift register; a new request waits until the frame ends.
module led_matrix_serial_writer_core (
    input  logic                     clk,
    input  logic                     rst_n,
    lmsw_req_if.sink                 req,
    lmsw_res_if.source               res,
    input  logic                     cfg_we,
    input  logic [lmsw_pkg::CMD_W-1:0] cfg_data
);
    import lmsw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [FRAME_W-1:0]       shift_reg, shift_next;
    logic [COUNT_W-1:0]       bits_left_reg, bits_left_next;
    logic                     first_reg, first_next;
    logic [CMD_W-1:0]         base_reg;
    logic [NIBBLE_ADDRESSES-1:0] valid_reg;

    logic [FRAME_ADDR_W-1:0]  addr_reg;
    logic [1:0]               bit_sel_reg;
    logic                     led_value_reg;

    logic                     req_fire;
    logic                     res_fire;
    logic [FRAME_ADDR_W-1:0]  req_addr;
    logic                     addr_ok;
    logic [NIBBLE_W-1:0]      level_clamped;
    logic [CMD_W-1:0]         cmd_sel;
    logic [NIBBLE_W-1:0]      nib_old;
    logic [NIBBLE_W-1:0]      nib_mask;
    logic [NIBBLE_W-1:0]      nib_new;
    logic [NIBBLE_W-1:0]      nib_rev;
    logic [NIBBLE_W-1:0]      ram_rdata;
    logic                     ram_we;

    assign req_fire = req.valid && req.ready;
    assign res_fire = res.valid && res.ready;

    // Nibble address and range check for a set-LED request.
    assign req_addr = req.led_index[LED_INDEX_W-1:2];
    assign addr_ok  = (32'(req_addr) < NIBBLE_ADDRESSES);

    // Clamp the signed brightness level to 0..15.
    always_comb
    begin
        if (req.level[LEVEL_W-1])
        begin
            level_clamped = '0;
        end
        else if (req.level[LEVEL_W-2:NIBBLE_W] != '0)
        begin
            level_clamped = LEVEL_MAX;
        end
        else
        begin
            level_clamped = req.level[NIBBLE_W-1:0];
        end
    end

    assign cmd_sel = (req.op == OP_BRIGHTNESS) ? (base_reg | {4'b0000, level_clamped})
                                               : req.cmd_byte;

    // Shadow store: registered read in the accept cycle, write back in the cycle after it.
    lmsw_ram #(
        .WIDTH (NIBBLE_W),
        .DEPTH (NIBBLE_ADDRESSES)
    ) u_shadow (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg[RAM_ADDR_W-1:0]),
        .wdata (nib_new),
        .raddr (req_addr[RAM_ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Update one bit of the nibble; never-written nibbles read as zero.
    assign nib_old  = valid_reg[addr_reg[RAM_ADDR_W-1:0]] ? ram_rdata : '0;
    assign nib_mask = NIBBLE_W'(1) << bit_sel_reg;
    assign nib_new  = led_value_reg ? (nib_old | nib_mask) : (nib_old & ~nib_mask);
    assign nib_rev  = {nib_new[0], nib_new[1], nib_new[2], nib_new[3]};
    assign ram_we   = (state_reg == ST_READ);

    // Sequencer and bit-serial shift register, MSB first.
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        first_next     = first_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.op inside {OP_RAW_CMD, OP_BRIGHTNESS})
                    begin
                        shift_next     = {ID_COMMAND, cmd_sel, 1'b0, 2'b00};
                        bits_left_next = CMD_FRAME_BITS;
                        first_next     = 1'b1;
                        state_next     = ST_SHIFT;
                    end
                    else if (req.op == OP_SET_LED && addr_ok)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                shift_next     = {ID_WRITE, addr_reg, nib_rev};
                bits_left_next = LED_FRAME_BITS;
                first_next     = 1'b1;
                state_next     = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (res_fire)
                begin
                    shift_next     = {shift_reg[FRAME_W-2:0], 1'b0};
                    bits_left_next = bits_left_reg - 1'b1;
                    first_next     = 1'b0;
                    if (bits_left_reg == 4'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bits_left_reg <= '0;
            first_reg     <= 1'b0;
            base_reg      <= BRIGHTNESS_BASE_RESET;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_left_reg <= bits_left_next;
            first_reg     <= first_next;
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
            if (ram_we)
            begin
                valid_reg[addr_reg[RAM_ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (req_fire)
        begin
            addr_reg      <= req_addr;
            bit_sel_reg   <= req.led_index[1:0];
            led_value_reg <= req.led_value;
        end
    end

    // Port outputs.
    assign req.ready       = (state_reg == ST_IDLE);
    assign res.valid       = (state_reg == ST_SHIFT);
    assign res.data_bit    = shift_reg[FRAME_W-1];
    assign res.frame_first = first_reg;
    assign res.last        = (bits_left_reg == 4'd1);

    // A result is only offered while bits of the frame remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (bits_left_reg != '0))
        else $error("result offered with no frame bits left");

    // The first bit of a frame comes with a full frame count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.frame_first) |->
            (bits_left_reg == CMD_FRAME_BITS || bits_left_reg == LED_FRAME_BITS))
        else $error("frame start with a wrong bit count");

    // After the last bit is taken, the writer returns to idle and no bit follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res.last) |=> (!res.valid && req.ready))
        else $error("frame did not end after its last bit");

    // A set-LED request within the store always goes through the read-modify cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.op == OP_SET_LED && addr_ok) |=> (ram_we && !res.valid))
        else $error("set-LED request skipped the shadow update");
endmodule
